@@ src/brlt_pkg.sv @@
// ----------------------------------------------------------------------------
// brlt_pkg: shared types and constants of the byte-range lock table
// Holds the table sizes, entry record, request opcodes, reply codes and the
// controller states used by the controller and the datapath.
// ----------------------------------------------------------------------------
package brlt_pkg;

  localparam int HELD_DEPTH = 16;
  localparam int WAIT_DEPTH = 16;
  localparam int HIW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int WIW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int HCW = $clog2(HELD_DEPTH + 1);
  localparam int WCW = $clog2(WAIT_DEPTH + 1);
  localparam logic [62:0] END_MAX = {63{1'b1}};

  typedef enum logic [1:0] {
    OP_TRY     = 2'd0,
    OP_BLOCK   = 2'd1,
    OP_UNLOCK  = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_GRANTED   = 4'd0,
    ST_QUEUED    = 4'd1,
    ST_BUSY      = 4'd2,
    ST_UNLOCKED  = 4'd3,
    ST_NOMATCH   = 4'd4,
    ST_FULL      = 4'd5,
    ST_LATE      = 4'd6,
    ST_CANCELLED = 4'd7,
    ST_RELEASED  = 4'd8
  } status_t;

  typedef struct packed {
    logic [62:0] start;
    logic [62:0] fin;
    logic        excl;
    logic [31:0] owner;
    logic [7:0]  client;
    logic [7:0]  tag;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_JUDGE,
    S_DECIDE,
    S_UNLK,
    S_HSHIFT,
    S_RCANCEL,
    S_RHELD,
    S_PLOAD,
    S_PJUDGE,
    S_PDECIDE,
    S_REPLY
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic     capture;     // latch request
    logic     scan_clr;    // clear scan flags and index
    logic     scan_held;   // examine one held entry (judge)
    logic     scan_wait;   // examine one queued entry (judge)
    logic     do_hold;     // append candidate to held table
    logic     do_queue;    // append candidate to queue
    logic     unlk_step;   // examine one held entry for unlock, newest first
    logic     shift_step;  // move one held entry down over removed slot
    logic     rc_step;     // release: examine one queued entry
    logic     rh_step;     // release: examine one held entry, newest first
    logic     pass_init;   // start queue pass
    logic     pass_load;   // pick queued entry as candidate
    logic     pass_keep;   // keep queued entry (compact)
    logic     pass_next;   // advance pass index
    logic     pass_end;    // set queue count to kept count
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic     held_done;
    logic     wait_done;
    logic     kept_busy;
    logic     must_wait;
    logic     held_full;
    logic     wait_full;
    logic     unlk_hit;
    logic     unlk_done;
    logic     shift_done;
    logic     rc_hit;
    logic     rc_done;
    logic     rh_done;
    logic     removed;
    logic     pass_done;
    logic     op_lock;
    logic     op_block;
    logic     op_unlock;
  } stat_t;

endpackage

@@ src/brlt_datapath.sv @@
// ----------------------------------------------------------------------------
// brlt_datapath: lock table storage and per-entry compare logic
// Holds the granted table and the wait queue in registers and examines one
// entry a cycle under control of the controller.
// ----------------------------------------------------------------------------
module brlt_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  brlt_pkg::cmd_t      cmd,
  output brlt_pkg::stat_t     stat,
  input  logic [1:0]          req_op,
  input  logic                req_kind,
  input  logic [62:0]         req_start,
  input  logic [62:0]         req_length,
  input  logic [31:0]         req_owner,
  input  logic [7:0]          req_client,
  input  logic [7:0]          req_tag,
  output logic [7:0]          cur_tag,
  output logic [7:0]          pass_tag,
  output logic [7:0]          rc_tag
);

  brlt_pkg::entry_t held_r [brlt_pkg::HELD_DEPTH];
  brlt_pkg::entry_t wait_r [brlt_pkg::WAIT_DEPTH];
  logic [brlt_pkg::HCW-1:0] hcnt_r;
  logic [brlt_pkg::WCW-1:0] wcnt_r;
  brlt_pkg::entry_t req_r, cand_r;
  logic [1:0] op_r;
  logic [brlt_pkg::HCW-1:0] hidx_r;
  logic [brlt_pkg::WCW-1:0] widx_r, keep_r, qlim_r;
  logic clash_r, qclash_r, has_r, hit_r, removed_r;
  logic [63:0] sum;
  logic [62:0] fin_c;
  brlt_pkg::entry_t he, we, ke, ce;
  logic hov, wov, kov, hsame, wsame, ksame;
  logic qs_busy;
  logic [brlt_pkg::WCW-1:0] qs_idx;

  brlt_qscan u_qs (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.pass_load),
    .limit (keep_r),
    .busy  (qs_busy),
    .idx   (qs_idx)
  );

  assign sum = {1'b0, req_start} + {1'b0, req_length} - 64'd1;
  always_comb begin
    if (req_length == 63'd0 || sum[63]) begin
      fin_c = brlt_pkg::END_MAX;
    end else begin
      fin_c = sum[62:0];
    end
  end

  assign he = held_r[hidx_r[brlt_pkg::HIW-1:0]];
  assign we = wait_r[widx_r[brlt_pkg::WIW-1:0]];
  assign ke = wait_r[qs_idx[brlt_pkg::WIW-1:0]];
  assign ce = cand_r;
  assign hov = ce.fin >= he.start && he.fin >= ce.start && (ce.excl || he.excl);
  assign wov = ce.fin >= we.start && we.fin >= ce.start && (ce.excl || we.excl);
  assign kov = ce.fin >= ke.start && ke.fin >= ce.start && (ce.excl || ke.excl);
  assign hsame = he.owner == ce.owner && he.client == ce.client;
  assign wsame = we.owner == ce.owner && we.client == ce.client;
  assign ksame = ke.owner == ce.owner && ke.client == ce.client;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= '0;
      wcnt_r <= '0;
    end else begin
      if (cmd.capture) begin
        req_r <= '{start: req_start, fin: fin_c, excl: req_kind, owner: req_owner,
                   client: req_client, tag: req_tag};
        cand_r <= '{start: req_start, fin: fin_c, excl: req_kind, owner: req_owner,
                    client: req_client, tag: req_tag};
        op_r <= req_op;
        qlim_r <= wcnt_r;
        removed_r <= 1'b0;
        hit_r <= 1'b0;
        hidx_r <= hcnt_r;
        widx_r <= '0;
        keep_r <= '0;
      end
      if (cmd.scan_clr || cmd.pass_load) begin
        clash_r <= 1'b0;
        qclash_r <= 1'b0;
        has_r <= 1'b0;
      end else begin
        if (cmd.scan_held && !hsame && hov) begin
          clash_r <= 1'b1;
        end
        if ((cmd.scan_wait && wov) || (qs_busy && kov)) begin
          qclash_r <= 1'b1;
        end
        if ((cmd.scan_held && hsame) || (cmd.scan_wait && wsame) || (qs_busy && ksame)) begin
          has_r <= 1'b1;
        end
      end
      if (cmd.scan_clr) begin
        hidx_r <= '0;
        widx_r <= '0;
      end
      if (cmd.scan_held) begin
        hidx_r <= hidx_r + 1'b1;
      end
      if (cmd.scan_wait) begin
        widx_r <= widx_r + 1'b1;
      end
      if (cmd.do_hold) begin
        held_r[hcnt_r[brlt_pkg::HIW-1:0]] <= cand_r;
        hcnt_r <= hcnt_r + 1'b1;
      end
      if (cmd.do_queue) begin
        wait_r[wcnt_r[brlt_pkg::WIW-1:0]] <= cand_r;
        wcnt_r <= wcnt_r + 1'b1;
      end
      if (cmd.unlk_step) begin
        if (held_r[hidx_r[brlt_pkg::HIW-1:0] - 1'b1].start == req_r.start &&
            held_r[hidx_r[brlt_pkg::HIW-1:0] - 1'b1].fin == req_r.fin &&
            held_r[hidx_r[brlt_pkg::HIW-1:0] - 1'b1].owner == req_r.owner &&
            held_r[hidx_r[brlt_pkg::HIW-1:0] - 1'b1].client == req_r.client) begin
          hit_r <= 1'b1;
          removed_r <= 1'b1;
        end
        hidx_r <= hidx_r - 1'b1;
      end
      if (cmd.shift_step) begin
        if (hidx_r + 1'b1 < hcnt_r) begin
          held_r[hidx_r[brlt_pkg::HIW-1:0]] <= held_r[hidx_r[brlt_pkg::HIW-1:0] + 1'b1];
          hidx_r <= hidx_r + 1'b1;
        end else begin
          hcnt_r <= hcnt_r - 1'b1;
          hit_r <= 1'b0;
          hidx_r <= hidx_r;
        end
      end
      if (cmd.rc_step) begin
        if (we.client == req_r.client) begin
          removed_r <= 1'b1;
        end else begin
          wait_r[keep_r[brlt_pkg::WIW-1:0]] <= we;
          keep_r <= keep_r + 1'b1;
        end
        widx_r <= widx_r + 1'b1;
        if (widx_r + 1'b1 >= wcnt_r) begin
          wcnt_r <= (we.client == req_r.client) ? keep_r : keep_r + 1'b1;
          hidx_r <= hcnt_r;
        end
      end
      if (cmd.rh_step) begin
        if (held_r[hidx_r[brlt_pkg::HIW-1:0] - 1'b1].client == req_r.client) begin
          hit_r <= 1'b1;
          removed_r <= 1'b1;
          hidx_r <= hidx_r - 1'b1;
        end else begin
          hidx_r <= hidx_r - 1'b1;
        end
      end
      if (cmd.pass_init) begin
        widx_r <= '0;
        keep_r <= '0;
      end
      if (cmd.pass_load) begin
        cand_r <= we;
        qlim_r <= keep_r;
        hidx_r <= '0;
      end
      if (cmd.pass_keep) begin
        wait_r[keep_r[brlt_pkg::WIW-1:0]] <= cand_r;
        keep_r <= keep_r + 1'b1;
      end
      if (cmd.pass_next) begin
        widx_r <= widx_r + 1'b1;
      end
      if (cmd.pass_end) begin
        wcnt_r <= keep_r;
      end
    end
  end

  // The first judge walks the queue with widx_r up to qlim_r. In a pass
  // widx_r holds the pass position and the kept entries below it are walked
  // by the scanner alongside the held scan.
  assign stat.held_done  = hidx_r >= hcnt_r;
  assign stat.wait_done  = widx_r >= qlim_r;
  assign stat.kept_busy  = qs_busy;
  assign stat.must_wait  = clash_r || (qclash_r && !has_r);
  assign stat.held_full  = hcnt_r == brlt_pkg::HCW'(brlt_pkg::HELD_DEPTH);
  assign stat.wait_full  = wcnt_r == brlt_pkg::WCW'(brlt_pkg::WAIT_DEPTH);
  assign stat.unlk_hit   = hit_r;
  assign stat.unlk_done  = hidx_r == '0;
  assign stat.shift_done = !hit_r;
  assign stat.rc_hit     = we.client == req_r.client;
  assign stat.rc_done    = widx_r >= wcnt_r;
  assign stat.rh_done    = hidx_r == '0;
  assign stat.removed    = removed_r;
  assign stat.pass_done  = widx_r >= wcnt_r;
  assign stat.op_lock    = op_r == brlt_pkg::OP_TRY || op_r == brlt_pkg::OP_BLOCK;
  assign stat.op_block   = op_r == brlt_pkg::OP_BLOCK;
  assign stat.op_unlock  = op_r == brlt_pkg::OP_UNLOCK;
  assign cur_tag  = req_r.tag;
  assign pass_tag = cand_r.tag;
  assign rc_tag   = we.tag;

endmodule

@@ src/brlt_controller.sv @@
// ----------------------------------------------------------------------------
// brlt_controller: request sequencer of the byte-range lock table
// Steps the datapath through judge, unlock, release and queue pass phases
// and issues the reply beats.
// ----------------------------------------------------------------------------
module brlt_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  output logic                in_ready,
  output brlt_pkg::cmd_t      cmd,
  input  brlt_pkg::stat_t     stat,
  input  logic [7:0]          cur_tag,
  input  logic [7:0]          pass_tag,
  input  logic [7:0]          rc_tag,
  output logic                rep_valid,
  input  logic                rep_ready,
  output logic [7:0]          rep_tag,
  output logic [3:0]          rep_status,
  output logic                rep_last
);

  brlt_pkg::state_t state_r, state_nxt;
  brlt_pkg::status_t fin_r, fin_nxt;
  logic in_pass_r, in_pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= brlt_pkg::S_IDLE;
      fin_r     <= brlt_pkg::ST_GRANTED;
      in_pass_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fin_r     <= fin_nxt;
      in_pass_r <= in_pass_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    fin_nxt     = fin_r;
    in_pass_nxt = in_pass_r;
    cmd         = '0;
    in_ready    = 1'b0;
    rep_valid   = 1'b0;
    rep_tag     = cur_tag;
    rep_status  = fin_r;
    rep_last    = 1'b1;
    unique case (state_r)
      brlt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.capture = 1'b1;
          state_nxt   = brlt_pkg::S_UNLK;
        end
      end
      brlt_pkg::S_UNLK: begin
        if (stat.op_lock) begin
          cmd.scan_clr = 1'b1;
          in_pass_nxt  = 1'b0;
          state_nxt    = brlt_pkg::S_JUDGE;
        end else if (stat.op_unlock) begin
          if (stat.unlk_hit) begin
            state_nxt = brlt_pkg::S_HSHIFT;
          end else if (stat.unlk_done) begin
            fin_nxt   = brlt_pkg::ST_NOMATCH;
            state_nxt = brlt_pkg::S_REPLY;
          end else begin
            cmd.unlk_step = 1'b1;
          end
        end else begin
          cmd.pass_init = 1'b1;
          state_nxt     = brlt_pkg::S_RCANCEL;
        end
      end
      brlt_pkg::S_HSHIFT: begin
        if (stat.shift_done) begin
          if (stat.op_unlock) begin
            fin_nxt   = brlt_pkg::ST_UNLOCKED;
            cmd.pass_init = 1'b1;
            state_nxt = brlt_pkg::S_PLOAD;
          end else begin
            state_nxt = brlt_pkg::S_RHELD;
          end
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      brlt_pkg::S_RCANCEL: begin
        if (stat.rc_done) begin
          state_nxt = brlt_pkg::S_RHELD;
        end else begin
          rep_tag    = rc_tag;
          rep_status = brlt_pkg::ST_CANCELLED;
          rep_last   = 1'b0;
          rep_valid  = stat.rc_hit;
          if (!stat.rc_hit || rep_ready) begin
            cmd.rc_step = 1'b1;
          end
        end
      end
      brlt_pkg::S_RHELD: begin
        fin_nxt = brlt_pkg::ST_RELEASED;
        if (stat.unlk_hit) begin
          state_nxt = brlt_pkg::S_HSHIFT;
        end else if (stat.rh_done) begin
          if (stat.removed) begin
            cmd.pass_init = 1'b1;
            state_nxt     = brlt_pkg::S_PLOAD;
          end else begin
            state_nxt = brlt_pkg::S_REPLY;
          end
        end else begin
          cmd.rh_step = 1'b1;
        end
      end
      brlt_pkg::S_JUDGE: begin
        if (!stat.held_done) begin
          cmd.scan_held = 1'b1;
        end else if (!stat.wait_done) begin
          cmd.scan_wait = 1'b1;
        end else begin
          state_nxt = in_pass_r ? brlt_pkg::S_PDECIDE : brlt_pkg::S_DECIDE;
        end
      end
      brlt_pkg::S_DECIDE: begin
        state_nxt = brlt_pkg::S_REPLY;
        if (!stat.must_wait) begin
          if (stat.held_full) begin
            fin_nxt = brlt_pkg::ST_FULL;
          end else begin
            cmd.do_hold = 1'b1;
            fin_nxt     = brlt_pkg::ST_GRANTED;
          end
        end else if (!stat.op_block) begin
          fin_nxt = brlt_pkg::ST_BUSY;
        end else if (stat.wait_full) begin
          fin_nxt = brlt_pkg::ST_FULL;
        end else begin
          cmd.do_queue = 1'b1;
          fin_nxt      = brlt_pkg::ST_QUEUED;
        end
      end
      brlt_pkg::S_PLOAD: begin
        if (stat.pass_done) begin
          cmd.pass_end = 1'b1;
          state_nxt    = brlt_pkg::S_REPLY;
        end else begin
          cmd.pass_load = 1'b1;
          in_pass_nxt   = 1'b1;
          state_nxt     = brlt_pkg::S_PJUDGE;
        end
      end
      brlt_pkg::S_PJUDGE: begin
        // Held entries and the kept part of the queue are scanned side by
        // side; the decision waits until both are done.
        if (!stat.held_done) begin
          cmd.scan_held = 1'b1;
        end else if (!stat.kept_busy) begin
          state_nxt = brlt_pkg::S_PDECIDE;
        end
      end
      brlt_pkg::S_PDECIDE: begin
        if (stat.must_wait || stat.held_full) begin
          cmd.pass_keep = 1'b1;
          cmd.pass_next = 1'b1;
          state_nxt     = brlt_pkg::S_PLOAD;
        end else begin
          rep_valid  = 1'b1;
          rep_tag    = pass_tag;
          rep_status = brlt_pkg::ST_LATE;
          rep_last   = 1'b0;
          if (rep_ready) begin
            cmd.do_hold   = 1'b1;
            cmd.pass_next = 1'b1;
            state_nxt     = brlt_pkg::S_PLOAD;
          end
        end
      end
      brlt_pkg::S_REPLY: begin
        rep_valid = 1'b1;
        if (rep_ready) begin
          state_nxt = brlt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = brlt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ src/brlt_qscan.sv @@
// ----------------------------------------------------------------------------
// brlt_qscan: kept-queue index walker for the queue pass
// Steps a read index over the queued entries kept so far during a pass, one
// a cycle, and stays busy while the index is valid.
// ----------------------------------------------------------------------------
module brlt_qscan (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [brlt_pkg::WCW-1:0] limit,
  output logic                     busy,
  output logic [brlt_pkg::WCW-1:0] idx
);

  logic [brlt_pkg::WCW-1:0] idx_r;
  logic                     busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
    end else if (start) begin
      idx_r  <= '0;
      busy_r <= limit != '0;
    end else if (busy_r) begin
      idx_r  <= idx_r + brlt_pkg::WCW'(1);
      busy_r <= idx_r + brlt_pkg::WCW'(1) < limit;
    end
  end

  assign busy = busy_r;
  assign idx  = idx_r;

endmodule

@@ src/byte_range_lock_table_core.sv @@
// ----------------------------------------------------------------------------
// byte_range_lock_table_core: byte-range lock manager
// Grants, queues and releases byte-range locks held in a sixteen-entry
// table with a sixteen-entry wait queue.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_tready is high only while the block is
// idle. A lock request scans every granted entry and then every queued
// entry, one a cycle. Unlock searches the table newest first and closes the
// gap one entry a cycle; a release also rescans the entries above each
// removed one. When either removes an entry it then passes over the queue,
// and each queued entry is judged against the granted entries and the
// entries kept so far. Every reply beat holds until out_tready.
module byte_range_lock_table_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[1:0], lock_kind[2], range_start[65:3], range_length[128:66],
  // owner_id[160:129], client_id[168:161], request_tag[176:169]
  input  logic [183:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // reply_tag[7:0], status[11:8]
  output logic [15:0]  out_tdata,
  output logic         out_tlast
);

  brlt_pkg::cmd_t  cmd;
  brlt_pkg::stat_t stat;
  logic [7:0] cur_tag, pass_tag, rc_tag, rep_tag;
  logic [3:0] rep_status;
  logic       in_fire;

  assign in_fire = in_tvalid && in_tready;

  brlt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .req_op     (in_tdata[1:0]),
    .req_kind   (in_tdata[2]),
    .req_start  (in_tdata[65:3]),
    .req_length (in_tdata[128:66]),
    .req_owner  (in_tdata[160:129]),
    .req_client (in_tdata[168:161]),
    .req_tag    (in_tdata[176:169]),
    .cur_tag    (cur_tag),
    .pass_tag   (pass_tag),
    .rc_tag     (rc_tag)
  );

  brlt_controller u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_ready   (in_tready),
    .cmd        (cmd),
    .stat       (stat),
    .cur_tag    (cur_tag),
    .pass_tag   (pass_tag),
    .rc_tag     (rc_tag),
    .rep_valid  (out_tvalid),
    .rep_ready  (out_tready),
    .rep_tag    (rep_tag),
    .rep_status (rep_status),
    .rep_last   (out_tlast)
  );

  assign out_tdata = {4'd0, rep_status, rep_tag};

endmodule
